// File: rtl/core/biquad_cascade_equalizer_top_assert.svh
// assertion macros for the biquad cascade equalizer checker
`ifndef BIQUAD_CASCADE_EQUALIZER_TOP_ASSERT_SVH
`define BIQUAD_CASCADE_EQUALIZER_TOP_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define BQEQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define BQEQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bqeq_pkg.sv
// shared types, constants and helpers of the biquad cascade equalizer
package bqeq_pkg;

    // parameter defaults
    localparam int DEF_BAND_COUNT         = 5;
    localparam int DEF_MAX_CHANNELS       = 2;
    localparam int DEF_SAMPLE_WIDTH       = 24;
    localparam int DEF_COEF_FRACTION_BITS = 28;

    // fixed widths
    localparam int COEFS_PER_BAND = 5;
    localparam int COEF_W         = 32;
    localparam int WORK_W         = 32;
    localparam int DELAY_W        = 48;
    localparam int ACC_W          = DELAY_W + 2;
    localparam int PROD_W         = COEF_W + WORK_W;
    localparam int PREAMP_FRAC    = 16;
    localparam int GAIN_W         = 17;
    localparam int CC_W           = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 17;
    localparam int FIELD_BAND_W   = 3;
    localparam int FIELD_CIDX_W   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMP_GAIN   = 2'd2;

    localparam logic [CC_W-1:0]   CC_RESET   = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd65536;

    // operation codes of an input beat
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // coefficient slots within a band
    localparam logic [FIELD_CIDX_W-1:0] COEF_B0 = 3'd0;
    localparam logic [FIELD_CIDX_W-1:0] COEF_B1 = 3'd1;
    localparam logic [FIELD_CIDX_W-1:0] COEF_B2 = 3'd2;
    localparam logic [FIELD_CIDX_W-1:0] COEF_A1 = 3'd3;
    localparam logic [FIELD_CIDX_W-1:0] COEF_A2 = 3'd4;

    // multiply step codes
    typedef logic [2:0] t_code;
    localparam t_code CMD_PRE = 3'd0;
    localparam t_code CMD_B0  = 3'd1;
    localparam t_code CMD_B1  = 3'd2;
    localparam t_code CMD_B2  = 3'd3;
    localparam t_code CMD_A1  = 3'd4;
    localparam t_code CMD_A2  = 3'd5;

    typedef struct packed {
        logic  take_sample;
        logic  take_coef;
        logic  issue;
        t_code code;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic filter_en;
        logic out_free;
    } t_stat;

    function automatic logic [FIELD_CIDX_W-1:0] code_slot(input t_code code);
        logic [FIELD_CIDX_W-1:0] slot;
        case (code)
            CMD_B1:  slot = COEF_B1;
            CMD_B2:  slot = COEF_B2;
            CMD_A1:  slot = COEF_A1;
            CMD_A2:  slot = COEF_A2;
            default: slot = COEF_B0;
        endcase
        return slot;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(
        input logic signed [ACC_W-1:0] v,
        input int unsigned             bits
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) << (bits - 1)) - ACC_W'(1);
        lo = ~hi;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

// File: rtl/core/bqeq_dp.sv
// datapath: config registers, coefficient and delay stores, shared multiply-accumulate
module bqeq_dp #(
    parameter int BAND_COUNT         = bqeq_pkg::DEF_BAND_COUNT,
    parameter int MAX_CHANNELS       = bqeq_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_WIDTH       = bqeq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_FRACTION_BITS = bqeq_pkg::DEF_COEF_FRACTION_BITS,
    parameter int BAND_W             = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [bqeq_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [bqeq_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    input  bqeq_pkg::t_cmd                          i_cmd,
    input  logic [BAND_W-1:0]                       i_band,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_sample_in,
    input  logic [bqeq_pkg::FIELD_BAND_W-1:0]       i_band_index,
    input  logic [bqeq_pkg::FIELD_CIDX_W-1:0]       i_coefficient_index,
    input  logic signed [bqeq_pkg::COEF_W-1:0]      i_coefficient_value,
    input  logic                                    i_out_ready,
    output bqeq_pkg::t_stat                         o_stat,
    output logic                                    o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]          o_sample_out,
    output logic                                    o_sample_channel,
    output logic                                    o_clipped
);

    localparam int COEF_DEPTH = BAND_COUNT * bqeq_pkg::COEFS_PER_BAND;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int DLY_DEPTH  = BAND_COUNT * MAX_CHANNELS;
    localparam int DLY_AW     = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;
    localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W      = ($clog2(MAX_CHANNELS + 1) > bqeq_pkg::CC_W)
                                ? $clog2(MAX_CHANNELS + 1) : bqeq_pkg::CC_W;
    localparam int WW         = bqeq_pkg::WORK_W;
    localparam int AW         = bqeq_pkg::ACC_W;
    localparam int PW         = bqeq_pkg::PROD_W;
    localparam int DW         = bqeq_pkg::DELAY_W;

    localparam logic signed [bqeq_pkg::COEF_W-1:0] COEF_ONE =
        bqeq_pkg::COEF_W'(1) << COEF_FRACTION_BITS;
    localparam logic signed [PW-1:0] RND_PRE = PW'(1) << (bqeq_pkg::PREAMP_FRAC - 1);
    localparam logic signed [PW-1:0] RND_CF  = PW'(1) << (COEF_FRACTION_BITS - 1);
    localparam logic signed [WW-1:0] OUT_MAX = 32'sh7FFF_FFFF >>> (WW - SAMPLE_WIDTH);
    localparam logic signed [WW-1:0] OUT_MIN = ~OUT_MAX;

    // config registers
    logic                        r_cfg_en;
    logic [bqeq_pkg::CC_W-1:0]   r_cfg_cc;
    logic [bqeq_pkg::GAIN_W-1:0] r_cfg_gain;

    // per-item state
    logic [CH_W-1:0]               r_ptr;
    logic [CH_W-1:0]               r_ch;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [WW-1:0]          r_s;
    logic signed [AW-1:0]          r_acc1;
    logic signed [AW-1:0]          r_acc2;

    // stores
    logic [bqeq_pkg::COEF_W-1:0] r_coef_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0]       r_coef_vld;
    logic [DW-1:0]               r_d1_mem [DLY_DEPTH];
    logic [DW-1:0]               r_d2_mem [DLY_DEPTH];
    logic [DLY_DEPTH-1:0]        r_d1_vld;
    logic [DLY_DEPTH-1:0]        r_d2_vld;

    // pipeline stage 1: operands
    logic                          r_s1_vld;
    bqeq_pkg::t_code               r_s1_code;
    logic [BAND_W-1:0]             r_s1_band;
    logic signed [WW-1:0]          r_mb;
    logic signed [bqeq_pkg::COEF_W-1:0] r_cq;
    logic                          r_cvld;

    // pipeline stage 2: product and delay words
    logic                          r_s2_vld;
    bqeq_pkg::t_code               r_s2_code;
    logic [DLY_AW-1:0]             r_s2_daddr;
    logic signed [PW-1:0]          r_prod;
    logic signed [DW-1:0]          r_d1q;
    logic signed [DW-1:0]          r_d2q;
    logic                          r_d1v;
    logic                          r_d2v;

    // output register
    logic                          r_out_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                          r_out_ch;
    logic                          r_out_clip;

    logic [CNT_W-1:0]              w_count;
    logic [CH_W-1:0]               w_ch;
    logic [CH_W-1:0]               w_ch_next;
    logic                          w_cwe;
    logic [COEF_AW-1:0]            w_cwaddr;
    logic [COEF_AW-1:0]            w_caddr;
    logic [DLY_AW-1:0]             w_s1_daddr;
    logic signed [bqeq_pkg::COEF_W-1:0] w_ma;
    logic signed [PW-1:0]          w_rnd_pre;
    logic signed [PW-1:0]          w_rnd_cf;
    logic signed [AW-1:0]          w_pre;
    logic signed [AW-1:0]          w_rc;
    logic signed [AW-1:0]          w_d1;
    logic signed [AW-1:0]          w_d2;
    logic signed [AW-1:0]          w_y;
    logic signed [AW-1:0]          w_z1;
    logic signed [AW-1:0]          w_z2;
    logic signed [SAMPLE_WIDTH-1:0] w_out_sample;
    logic                          w_out_clip;

    // channel pointer with count clamped to one..MAX_CHANNELS
    always_comb begin
        w_count = CNT_W'(r_cfg_cc);
        if (w_count == '0) begin
            w_count = CNT_W'(1);
        end else if (w_count > CNT_W'(MAX_CHANNELS)) begin
            w_count = CNT_W'(MAX_CHANNELS);
        end
        w_ch      = (CNT_W'(r_ptr) >= w_count) ? '0 : r_ptr;
        w_ch_next = ((CNT_W'(w_ch) + CNT_W'(1)) >= w_count) ? '0 : CH_W'(w_ch + CH_W'(1));
    end

    assign w_cwe = i_cmd.take_coef
                   && (int'(i_band_index) < BAND_COUNT)
                   && (int'(i_coefficient_index) < bqeq_pkg::COEFS_PER_BAND);
    assign w_cwaddr = COEF_AW'(int'(i_band_index) * bqeq_pkg::COEFS_PER_BAND
                               + int'(i_coefficient_index));
    assign w_caddr = COEF_AW'(int'(i_band) * bqeq_pkg::COEFS_PER_BAND
                              + int'(bqeq_pkg::code_slot(i_cmd.code)));
    assign w_s1_daddr = DLY_AW'(int'(r_s1_band) * MAX_CHANNELS + int'(r_ch));

    // unwritten coefficient reads as the identity section
    always_comb begin
        if (r_s1_code == bqeq_pkg::CMD_PRE) begin
            w_ma = signed'(bqeq_pkg::COEF_W'(r_cfg_gain));
        end else if (r_cvld) begin
            w_ma = r_cq;
        end else if (r_s1_code == bqeq_pkg::CMD_B0) begin
            w_ma = COEF_ONE;
        end else begin
            w_ma = '0;
        end
    end

    // round to nearest, ties up, then back into the accumulator width
    assign w_rnd_pre = (r_prod + RND_PRE) >>> bqeq_pkg::PREAMP_FRAC;
    assign w_rnd_cf  = (r_prod + RND_CF) >>> COEF_FRACTION_BITS;
    assign w_pre     = AW'(w_rnd_pre);
    assign w_rc      = AW'(w_rnd_cf);
    assign w_d1      = r_d1v ? AW'(r_d1q) : '0;
    assign w_d2      = r_d2v ? AW'(r_d2q) : '0;
    assign w_y       = w_rc + w_d1;
    assign w_z1      = r_acc1 - w_rc;
    assign w_z2      = r_acc2 - w_rc;

    always_comb begin
        if (!r_cfg_en) begin
            w_out_sample = r_x;
            w_out_clip   = 1'b0;
        end else if (r_s > OUT_MAX) begin
            w_out_sample = SAMPLE_WIDTH'(OUT_MAX);
            w_out_clip   = 1'b1;
        end else if (r_s < OUT_MIN) begin
            w_out_sample = SAMPLE_WIDTH'(OUT_MIN);
            w_out_clip   = 1'b1;
        end else begin
            w_out_sample = SAMPLE_WIDTH'(r_s);
            w_out_clip   = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_en   <= 1'b0;
            r_cfg_cc   <= bqeq_pkg::CC_RESET;
            r_cfg_gain <= bqeq_pkg::GAIN_RESET;
            r_ptr      <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bqeq_pkg::CFG_FILTER_ENABLE: r_cfg_en   <= i_cfg_wdata[0];
                    bqeq_pkg::CFG_CHANNEL_COUNT: r_cfg_cc   <= i_cfg_wdata[bqeq_pkg::CC_W-1:0];
                    bqeq_pkg::CFG_PREAMP_GAIN:   r_cfg_gain <= i_cfg_wdata[bqeq_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.take_sample) begin
                r_ptr <= w_ch_next;
            end
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // valid bits of the stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
            r_d1_vld   <= '0;
            r_d2_vld   <= '0;
        end else begin
            if (w_cwe) begin
                r_coef_vld[w_cwaddr] <= 1'b1;
            end
            if (r_s2_vld && (r_s2_code == bqeq_pkg::CMD_A1)) begin
                r_d1_vld[r_s2_daddr] <= 1'b1;
            end
            if (r_s2_vld && (r_s2_code == bqeq_pkg::CMD_A2)) begin
                r_d2_vld[r_s2_daddr] <= 1'b1;
            end
        end
    end

    // coefficient store
    always_ff @(posedge i_clk) begin
        if (w_cwe) begin
            r_coef_mem[w_cwaddr] <= i_coefficient_value;
        end
        r_cq   <= r_coef_mem[w_caddr];
        r_cvld <= r_coef_vld[w_caddr];
    end

    // delay stores, read one stage ahead of the accumulate
    always_ff @(posedge i_clk) begin
        if (r_s2_vld && (r_s2_code == bqeq_pkg::CMD_A1)) begin
            r_d1_mem[r_s2_daddr] <= DW'(bqeq_pkg::sat_acc(w_z1, DW));
        end
        if (r_s2_vld && (r_s2_code == bqeq_pkg::CMD_A2)) begin
            r_d2_mem[r_s2_daddr] <= DW'(bqeq_pkg::sat_acc(w_z2, DW));
        end
        r_d1q <= r_d1_mem[w_s1_daddr];
        r_d2q <= r_d2_mem[w_s1_daddr];
        r_d1v <= r_d1_vld[w_s1_daddr];
        r_d2v <= r_d2_vld[w_s1_daddr];
    end

    // operand, multiply and accumulate stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample) begin
            r_x  <= i_sample_in;
            r_ch <= w_ch;
        end
        r_s1_code <= i_cmd.code;
        r_s1_band <= i_band;
        r_mb      <= (i_cmd.code == bqeq_pkg::CMD_PRE) ? WW'(r_x) : r_s;
        r_s2_code  <= r_s1_code;
        r_s2_daddr <= w_s1_daddr;
        r_prod     <= w_ma * r_mb;
        if (r_s2_vld) begin
            unique case (r_s2_code)
                bqeq_pkg::CMD_PRE: r_s    <= WW'(bqeq_pkg::sat_acc(w_pre, WW));
                bqeq_pkg::CMD_B0:  r_s    <= WW'(bqeq_pkg::sat_acc(w_y, WW));
                bqeq_pkg::CMD_B1:  r_acc1 <= w_d2 + w_rc;
                bqeq_pkg::CMD_B2:  r_acc2 <= w_rc;
                default: ;
            endcase
        end
        if (i_cmd.load_out) begin
            r_out_sample <= w_out_sample;
            r_out_ch     <= r_ch[0];
            r_out_clip   <= w_out_clip;
        end
    end

    assign o_stat.filter_en = r_cfg_en;
    assign o_stat.out_free  = !r_out_vld || i_out_ready;
    assign o_out_valid      = r_out_vld;
    assign o_sample_out     = r_out_sample;
    assign o_sample_channel = r_out_ch;
    assign o_clipped        = r_out_clip;

endmodule

// File: rtl/core/bqeq_ctrl.sv
// controller: sequences preamp and per-band multiply steps on the shared datapath
module bqeq_ctrl #(
    parameter int BAND_COUNT = bqeq_pkg::DEF_BAND_COUNT,
    parameter int BAND_W     = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_operation,
    input  bqeq_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output bqeq_pkg::t_cmd  o_cmd,
    output logic [BAND_W-1:0] o_band
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRE   = 3'd1;
    localparam logic [2:0] S_GAP   = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(BAND_COUNT - 1);

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [BAND_W-1:0]     r_band;
    logic [BAND_W-1:0]     n_band;
    bqeq_pkg::t_code       r_code;
    bqeq_pkg::t_code       n_code;
    logic                  r_wait;
    logic                  n_wait;
    logic                  w_take;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.take_sample = w_take && (i_operation == bqeq_pkg::OP_SAMPLE);
        o_cmd.take_coef   = w_take && (i_operation == bqeq_pkg::OP_COEF);
        o_cmd.issue       = (r_state == S_PRE) || (r_state == S_RUN);
        o_cmd.code        = (r_state == S_PRE) ? bqeq_pkg::CMD_PRE : r_code;
        o_cmd.load_out    = (r_state == S_FIN) && i_stat.out_free;
    end
    assign o_band = r_band;

    always_comb begin
        n_state = r_state;
        n_band  = r_band;
        n_code  = r_code;
        n_wait  = r_wait;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.take_sample) begin
                    n_state = i_stat.filter_en ? S_PRE : S_FIN;
                end
            end
            S_PRE: begin
                n_state = S_GAP;
                n_wait  = 1'b0;
                n_band  = '0;
                n_code  = bqeq_pkg::CMD_B0;
            end
            // hold until the preamp result has passed stage 1 and stage 2 into the accumulate
            S_GAP: begin
                n_wait = 1'b1;
                if (r_wait) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                unique case (r_code)
                    bqeq_pkg::CMD_B0: n_code = bqeq_pkg::CMD_B1;
                    bqeq_pkg::CMD_B1: n_code = bqeq_pkg::CMD_B2;
                    bqeq_pkg::CMD_B2: n_code = bqeq_pkg::CMD_A1;
                    bqeq_pkg::CMD_A1: n_code = bqeq_pkg::CMD_A2;
                    default: begin
                        n_code = bqeq_pkg::CMD_B0;
                        if (r_band == LAST_BAND) begin
                            n_state = S_DRAIN;
                            n_wait  = 1'b0;
                        end else begin
                            n_band = BAND_W'(r_band + BAND_W'(1));
                        end
                    end
                endcase
            end
            S_DRAIN: begin
                n_wait = 1'b1;
                if (r_wait) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_band  <= '0;
            r_code  <= bqeq_pkg::CMD_B0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_band  <= n_band;
            r_code  <= n_code;
            r_wait  <= n_wait;
        end
    end

endmodule

// File: rtl/core/biquad_cascade_equalizer_top.sv
// top level of the biquad cascade equalizer
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    operation, sample, band, coef index, coef
//  output    out        o_out_valid / i_out_ready  sample_out, sample_channel, clipped
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// a filtered sample goes through preamp, gap, band steps, drain and load; band steps issue
// one multiply a cycle through the single shared 32x32 multiplier and its 3-stage pipe.
// a pass-through sample goes from idle to output load; a coefficient write stays in idle.
// synchronous active-low reset; coefficients reset to identity, delay words to zero.
// a beat is taken while the previous result waits; the block stalls only at the end
// of an item if its result register is still full.
module biquad_cascade_equalizer_top #(
    parameter int BAND_COUNT         = bqeq_pkg::DEF_BAND_COUNT,
    parameter int MAX_CHANNELS       = bqeq_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_WIDTH       = bqeq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_FRACTION_BITS = bqeq_pkg::DEF_COEF_FRACTION_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bqeq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bqeq_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_in,
    input  logic [bqeq_pkg::FIELD_BAND_W-1:0]   i_band_index,
    input  logic [bqeq_pkg::FIELD_CIDX_W-1:0]   i_coefficient_index,
    input  logic signed [bqeq_pkg::COEF_W-1:0]  i_coefficient_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_out,
    output logic                                o_sample_channel,
    output logic                                o_clipped
);

    localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

    bqeq_pkg::t_cmd    w_cmd;
    bqeq_pkg::t_stat   w_stat;
    logic [BAND_W-1:0] w_band;

    bqeq_ctrl #(
        .BAND_COUNT (BAND_COUNT),
        .BAND_W     (BAND_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd),
        .o_band      (w_band)
    );

    bqeq_dp #(
        .BAND_COUNT         (BAND_COUNT),
        .MAX_CHANNELS       (MAX_CHANNELS),
        .SAMPLE_WIDTH       (SAMPLE_WIDTH),
        .COEF_FRACTION_BITS (COEF_FRACTION_BITS),
        .BAND_W             (BAND_W)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_cmd               (w_cmd),
        .i_band              (w_band),
        .i_sample_in         (i_sample_in),
        .i_band_index        (i_band_index),
        .i_coefficient_index (i_coefficient_index),
        .i_coefficient_value (i_coefficient_value),
        .i_out_ready         (i_out_ready),
        .o_stat              (w_stat),
        .o_out_valid         (o_out_valid),
        .o_sample_out        (o_sample_out),
        .o_sample_channel    (o_sample_channel),
        .o_clipped           (o_clipped)
    );

endmodule

// File: rtl/core/bqeq_chk.sv
// port-level checker of the biquad cascade equalizer, bound to the top level
`include "biquad_cascade_equalizer_top_assert.svh"

module bqeq_chk #(
    parameter int SAMPLE_WIDTH = bqeq_pkg::DEF_SAMPLE_WIDTH
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_operation,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input logic                           o_clipped
);

    localparam logic [SAMPLE_WIDTH-1:0] FS_POS = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] FS_NEG = ~FS_POS;

    logic w_sample_beat;
    logic w_stalled;
    logic w_at_full;

    assign w_sample_beat = i_in_valid && o_in_ready && (i_operation == bqeq_pkg::OP_SAMPLE);
    assign w_stalled     = o_out_valid && !i_out_ready;
    assign w_at_full     = (o_sample_out == FS_POS) || (o_sample_out == FS_NEG);

    // out of reset: empty and ready
    `BQEQ_ASSERT_IMP(a_reset_state, $past(!i_rst_n), !o_out_valid && o_in_ready, "bad state after reset")

    // a stalled result beat holds
    `BQEQ_ASSERT_NXT(a_out_hold, w_stalled, o_out_valid && $stable(o_sample_out), "result beat dropped")

    // one sample at a time
    `BQEQ_ASSERT_NXT(a_busy_after_sample, w_sample_beat, !o_in_ready, "second sample taken at once")

    // a clipped result sits at full scale
    `BQEQ_ASSERT_IMP(a_clip_full_scale, o_out_valid && o_clipped, w_at_full, "clip off full scale")

endmodule

bind biquad_cascade_equalizer_top bqeq_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chk (.*);

// File: test/tb_biquad_cascade_equalizer_top.sv
`timescale 1ns / 100ps
// testbench of the biquad cascade equalizer: directed and random beats checked against a local predictor
module tb_biquad_cascade_equalizer_top;
    import bqeq_pkg::*;

    localparam int     BANDS        = DEF_BAND_COUNT;
    localparam int     CHANS        = DEF_MAX_CHANNELS;
    localparam int     SW           = DEF_SAMPLE_WIDTH;
    localparam int     CFB          = DEF_COEF_FRACTION_BITS;
    localparam longint UNITY        = 64'sd1 <<< CFB;
    localparam int     DRAIN_CYCLES = 5 * BANDS + 7 + 8;
    localparam int     PHASES       = 6;

    typedef struct {
        logic                        op;
        logic signed [SW-1:0]        sample;
        logic [FIELD_BAND_W-1:0]     band;
        logic [FIELD_CIDX_W-1:0]     cidx;
        logic signed [COEF_W-1:0]    cval;
    } eq_beat_t;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 chan;
        logic                 clip;
    } eq_sample_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = CFG_FILTER_ENABLE;
    logic [CFG_DATA_W-1:0]       i_cfg_wdata = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic                        i_operation = OP_SAMPLE;
    logic signed [SW-1:0]        i_sample_in = '0;
    logic [FIELD_BAND_W-1:0]     i_band_index = '0;
    logic [FIELD_CIDX_W-1:0]     i_coefficient_index = '0;
    logic signed [COEF_W-1:0]    i_coefficient_value = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic signed [SW-1:0]        o_sample_out;
    logic                        o_sample_channel;
    logic                        o_clipped;

    eq_beat_t   pending_beats[$];
    eq_sample_t expected_samples[$];
    eq_beat_t   cur_beat;
    int         in_gap = 0;
    int         out_gap = 0;
    bit         idle_on = 1'b1;
    int         errors = 0;

    // predictor state
    longint      coef_bank [BANDS*COEFS_PER_BAND];
    longint      state_z1 [BANDS*CHANS];
    longint      state_z2 [BANDS*CHANS];
    int unsigned next_channel;
    bit          set_enable;
    int unsigned set_count;
    longint      set_gain;

    biquad_cascade_equalizer_top uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_operation         (i_operation),
        .i_sample_in         (i_sample_in),
        .i_band_index        (i_band_index),
        .i_coefficient_index (i_coefficient_index),
        .i_coefficient_value (i_coefficient_value),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_sample_out        (o_sample_out),
        .o_sample_channel    (o_sample_channel),
        .o_clipped           (o_clipped)
    );

    always #5 i_clk = ~i_clk;

    // round to nearest, ties upward, then drop n fraction bits
    function automatic longint scale_round(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_to(longint v, int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint coef_product(longint c, longint v);
        return scale_round(c * v, CFB);
    endfunction

    function automatic void equalize_beat(eq_beat_t bt);
        int unsigned n;
        int unsigned ch;
        int unsigned d;
        int unsigned k;
        int          b;
        longint      s;
        longint      y;
        longint      r;
        eq_sample_t  res;
        if (bt.op == OP_COEF) begin
            if (bt.band < BANDS && bt.cidx < COEFS_PER_BAND) begin
                coef_bank[bt.band * COEFS_PER_BAND + bt.cidx] = longint'(bt.cval);
            end
            return;
        end
        n = (set_count == 0) ? 1 : set_count;
        if (n > CHANS) n = CHANS;
        // a shrunk channel count restarts the interleave
        if (next_channel >= n) next_channel = 0;
        ch = next_channel;
        next_channel = (ch + 1 >= n) ? 0 : ch + 1;
        s = longint'(bt.sample);
        res.clip = 1'b0;
        if (!set_enable) begin
            r = s;
        end else begin
            s = clamp_to(scale_round(s * set_gain, PREAMP_FRAC), WORK_W);
            for (b = 0; b < BANDS; b++) begin
                d = b * CHANS + ch;
                k = b * COEFS_PER_BAND;
                y = clamp_to(coef_product(coef_bank[k], s) + state_z1[d], WORK_W);
                state_z1[d] = clamp_to(coef_product(coef_bank[k+1], s)
                                       - coef_product(coef_bank[k+3], y) + state_z2[d], DELAY_W);
                state_z2[d] = clamp_to(coef_product(coef_bank[k+2], s)
                                       - coef_product(coef_bank[k+4], y), DELAY_W);
                s = y;
            end
            r = clamp_to(s, SW);
            res.clip = (r != s);
        end
        res.sample = r[SW-1:0];
        res.chan = ch[0];
        expected_samples.push_back(res);
    endfunction

    function automatic void push_sample(logic signed [SW-1:0] v);
        eq_beat_t bt;
        bt.op = OP_SAMPLE;
        bt.sample = v;
        // unused fields carry junk
        bt.band = FIELD_BAND_W'($urandom());
        bt.cidx = FIELD_CIDX_W'($urandom());
        bt.cval = $urandom();
        pending_beats.push_back(bt);
    endfunction

    function automatic void push_coef(logic [FIELD_BAND_W-1:0] band,
                                      logic [FIELD_CIDX_W-1:0] cidx, longint v);
        eq_beat_t bt;
        bt.op = OP_COEF;
        bt.sample = SW'($urandom());
        bt.band = band;
        bt.cidx = cidx;
        bt.cval = v[COEF_W-1:0];
        pending_beats.push_back(bt);
    endfunction

    // poles kept inside the stability triangle, zeros near them
    function automatic void queue_stable_band(int band);
        longint pole1;
        longint pole2;
        longint span;
        pole2 = longint'($urandom_range(0, 230_000_000));
        span = ((UNITY + pole2) * 9) / 10;
        pole1 = longint'($urandom_range(0, 32'(2 * span))) - span;
        push_coef(band, COEF_B0, UNITY + longint'($urandom_range(0, 1 << 27)) - (1 << 26));
        push_coef(band, COEF_B1, pole1 + longint'($urandom_range(0, 1 << 25)) - (1 << 24));
        push_coef(band, COEF_B2, pole2 + longint'($urandom_range(0, 1 << 25)) - (1 << 24));
        push_coef(band, COEF_A1, pole1);
        push_coef(band, COEF_A2, pole2);
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0: begin
                return raw[0] ? 24'sh7FFFFF : 24'sh800000;
            end
            1, 2, 3, 4: begin
                return raw[SW-1:0];
            end
            default: begin
                return {{6{raw[17]}}, raw[17:0]};
            end
        endcase
    endfunction

    function automatic void queue_phase(int count, bit reload);
        int i;
        int roll;
        if (reload) begin
            for (i = 0; i < BANDS; i++) queue_stable_band(i);
        end
        for (i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                // address outside the store: must leave it alone
                if ($urandom_range(0, 1)) begin
                    push_coef($urandom_range(BANDS, 7), $urandom_range(0, 7),
                              longint'($urandom()));
                end else begin
                    push_coef($urandom_range(0, 7), $urandom_range(COEFS_PER_BAND, 7),
                              longint'($urandom()));
                end
            end else if (roll < 4) begin
                push_coef($urandom_range(0, BANDS - 1), $urandom_range(0, COEFS_PER_BAND - 1),
                          longint'(signed'($urandom())));
            end else if (roll < 6) begin
                queue_stable_band($urandom_range(0, BANDS - 1));
            end else begin
                push_sample(rand_sample());
            end
        end
    endfunction

    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || i_in_valid || expected_samples.size() != 0);
        // trailing coefficient writes give no result, so let the block settle
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_settings(logic en, logic [CC_W-1:0] cnt, logic [GAIN_W-1:0] gain);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_FILTER_ENABLE;
        i_cfg_wdata <= CFG_DATA_W'(en);
        @(posedge i_clk);
        i_cfg_index <= CFG_CHANNEL_COUNT;
        i_cfg_wdata <= CFG_DATA_W'(cnt);
        @(posedge i_clk);
        i_cfg_index <= CFG_PREAMP_GAIN;
        i_cfg_wdata <= CFG_DATA_W'(gain);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        set_enable = en;
        set_count = cnt;
        set_gain = longint'(gain);
        @(negedge i_clk);
    endtask

    // input side: one beat at a time from the pending queue
    always @(posedge i_clk) begin : drive_beats
        bit hold;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            hold = i_in_valid && !o_in_ready;
            if (i_in_valid && o_in_ready) equalize_beat(cur_beat);
            if (!hold) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() != 0 && idle_on
                             && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(0, 9);
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    cur_beat = pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= cur_beat.op;
                    i_sample_in <= cur_beat.sample;
                    i_band_index <= cur_beat.band;
                    i_coefficient_index <= cur_beat.cidx;
                    i_coefficient_value <= cur_beat.cval;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: random back-pressure and field checks
    always @(posedge i_clk) begin : take_results
        eq_sample_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("result beat with nothing expected: sample_out %0d", o_sample_out);
                    errors++;
                end else begin
                    want = expected_samples.pop_front();
                    if (o_sample_out !== want.sample) begin
                        $error("sample_out: expected %0d, actual %0d", want.sample, o_sample_out);
                        errors++;
                    end
                    if (o_sample_channel !== want.chan) begin
                        $error("sample_channel: expected %0d, actual %0d",
                               want.chan, o_sample_channel);
                        errors++;
                    end
                    if (o_clipped !== want.clip) begin
                        $error("clipped: expected %0d, actual %0d", want.clip, o_clipped);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(0, 9);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int          i;
        int          p;
        int          ph_enable [PHASES] = '{1, 1, 1, 1, 0, 1};
        int          ph_count [PHASES] = '{2, 1, 0, 3, 2, 2};
        logic [16:0] gain;
        for (i = 0; i < BANDS * COEFS_PER_BAND; i++) begin
            coef_bank[i] = (i % COEFS_PER_BAND == 0) ? UNITY : 0;
        end
        for (i = 0; i < BANDS * CHANS; i++) begin
            state_z1[i] = 0;
            state_z2[i] = 0;
        end
        next_channel = 0;
        set_enable = 1'b0;
        set_count = CC_RESET;
        set_gain = longint'(GAIN_RESET);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // settings out of reset: pass-through, writes outside the store ignored
        push_sample(24'sh7FFFFF);
        push_sample(24'sh800000);
        push_sample('0);
        push_sample(-1);
        push_coef(5, COEF_B0, 64'sh7FFFFFFF);
        push_coef(7, COEF_A2, -(64'sd1 <<< 31));
        push_coef(0, 5, -1);
        push_coef(4, 7, 64'sh55555555);
        push_coef(0, COEF_B0, 64'sh7FFFFFFF);
        push_sample(24'sh123456);
        wait_for_drain();

        // full preamp and near-eight b0: both rails clip, then negative b0
        write_settings(1'b1, 2'd2, 17'h1FFFF);
        push_sample(24'sh7FFFFF);
        push_sample(24'sh800000);
        push_sample(1);
        push_sample(-1);
        push_sample('0);
        push_coef(0, COEF_B0, -(64'sd1 <<< 31));
        push_sample(24'sh400000);
        push_coef(0, COEF_B0, UNITY);
        push_coef(2, COEF_B1, UNITY / 2);
        push_coef(3, COEF_A1, -UNITY / 4);
        push_sample(24'sh100000);
        push_sample(-24'sh0FFFFF);
        push_sample(24'sh7FFFFF);
        wait_for_drain();

        // odd count on two channels leaves the pointer on channel one
        write_settings(1'b1, 2'd1, 17'd0);
        push_sample(rand_sample());
        push_sample(rand_sample());

        for (p = 0; p < PHASES; p++) begin
            wait_for_drain();
            case (p)
                0, 5: gain = 17'd65536;
                1: gain = 17'h1FFFF;
                3: gain = 17'($urandom_range(32768, 98304));
                default: gain = 17'($urandom());
            endcase
            if (p == PHASES - 1) idle_on = 1'b0;
            write_settings(ph_enable[p][0], ph_count[p][1:0], gain);
            queue_phase(32, 1'b1);
            // sender holds off until the pipe is empty
            if (p == 2) wait_for_drain();
            queue_phase(33, 1'b0);
        end

        wait_for_drain();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(4ms);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bqeq_pkg.sv
rtl/core/bqeq_dp.sv
rtl/core/bqeq_ctrl.sv
rtl/core/biquad_cascade_equalizer_top.sv
rtl/core/bqeq_chk.sv
test/tb_biquad_cascade_equalizer_top.sv
